### rtl/core/affine_background_address_gen_top_macros.svh
// Assertion macros for the affine background address generator.
// Used by the top level only; no other dependencies.
`ifndef AFFINE_BACKGROUND_ADDRESS_GEN_TOP_MACROS_SVH
`define AFFINE_BACKGROUND_ADDRESS_GEN_TOP_MACROS_SVH

// same-cycle implication
`define AFFBG_AST_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("affbg: same-cycle check failed");

// next-cycle implication
`define AFFBG_AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("affbg: next-cycle check failed");

`endif

### rtl/core/affbg_pkg.sv
// Package for the affine background address generator: widths, codes, structs.
// No dependencies.
`default_nettype none

package affbg_pkg;

	localparam int LINE_PIXELS = 256;
	localparam int PIX_W       = $clog2(LINE_PIXELS);

	localparam int DX_W       = 16;
	localparam int ACC_W      = 32;
	localparam int REF_W      = 28;
	localparam int COORD_W    = ACC_W - 8;
	localparam int MW_W       = 5;
	localparam int MODE_W     = 3;
	localparam int SIZE_W     = 2;
	localparam int BASE_W     = 19;
	localparam int TEX_W      = 10;
	localparam int ADDR_W     = 20;
	localparam int PIXX_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;

	localparam logic [CFG_IDX_W-1:0] REG_DX         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DY         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOSAIC_EN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOSAIC_W   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_EN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LAYER_BASE = 3'd7;

	localparam logic [MODE_W-1:0] MODE_BYTE_MAP   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_HALF_MAP   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BYTE_BMP   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DIRECT_BMP = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LARGE_BMP  = 3'd4;

	typedef struct packed {
		logic signed [DX_W-1:0] dx;
		logic signed [DX_W-1:0] dy;
		logic                   mosaic_en;
		logic [MW_W-1:0]        mosaic_width;
		logic                   wrap_en;
		logic [MODE_W-1:0]      layer_mode;
		logic [SIZE_W-1:0]      size_sel;
		logic [BASE_W-1:0]      layer_base;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [PIXX_W-1:0]         pixel_x;
		logic                      line_end;
	} coord_t;

	typedef struct packed {
		logic [PIXX_W-1:0] pixel_x;
		logic [TEX_W-1:0]  tex_x;
		logic [TEX_W-1:0]  tex_y;
		logic              outside;
		logic [ADDR_W-1:0] fetch_address;
		logic              fetch_wide;
		logic              line_end;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/affbg_ifs.sv
// Channel interfaces: input items, result items and configuration writes.
// Depends on affbg_pkg.
`default_nettype none

interface affbg_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  start_line;
	logic signed [affbg_pkg::REF_W-1:0]    ref_x_in;
	logic signed [affbg_pkg::REF_W-1:0]    ref_y_in;

	modport source (output valid, start_line, ref_x_in, ref_y_in, input ready);
	modport sink   (input valid, start_line, ref_x_in, ref_y_in, output ready);
endinterface

interface affbg_out_if;
	logic                            valid;
	logic                            ready;
	logic [affbg_pkg::PIXX_W-1:0]    pixel_x;
	logic [affbg_pkg::TEX_W-1:0]     tex_x;
	logic [affbg_pkg::TEX_W-1:0]     tex_y;
	logic                            outside;
	logic [affbg_pkg::ADDR_W-1:0]    fetch_address;
	logic                            fetch_wide;
	logic                            line_end;

	modport source (output valid, pixel_x, tex_x, tex_y, outside, fetch_address,
		fetch_wide, line_end, input ready);
	modport sink   (input valid, pixel_x, tex_x, tex_y, outside, fetch_address,
		fetch_wide, line_end, output ready);
endinterface

interface affbg_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [affbg_pkg::CFG_IDX_W-1:0]     index;
	logic [affbg_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/affbg_cfg.sv
// Configuration register file, written over the configuration channel.
// Depends on affbg_pkg and affbg_ifs.
`default_nettype none

module affbg_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	affbg_cfg_if.sink        wr,
	output affbg_pkg::cfg_t  cfg_o
);

	affbg_pkg::cfg_t cfg_q;

	assign wr.ready = 1'b1;
	assign cfg_o    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dx           <= 16'sd256;
			cfg_q.dy           <= '0;
			cfg_q.mosaic_en    <= 1'b0;
			cfg_q.mosaic_width <= 5'd1;
			cfg_q.wrap_en      <= 1'b0;
			cfg_q.layer_mode   <= affbg_pkg::MODE_BYTE_MAP;
			cfg_q.size_sel     <= '0;
			cfg_q.layer_base   <= '0;
		end else if (wr.valid) begin
			unique case (wr.index)
				affbg_pkg::REG_DX:         cfg_q.dx <= $signed(wr.data[affbg_pkg::DX_W-1:0]);
				affbg_pkg::REG_DY:         cfg_q.dy <= $signed(wr.data[affbg_pkg::DX_W-1:0]);
				affbg_pkg::REG_MOSAIC_EN:  cfg_q.mosaic_en <= wr.data[0];
				affbg_pkg::REG_MOSAIC_W:   cfg_q.mosaic_width <= wr.data[affbg_pkg::MW_W-1:0];
				affbg_pkg::REG_WRAP_EN:    cfg_q.wrap_en <= wr.data[0];
				affbg_pkg::REG_MODE:       cfg_q.layer_mode <= wr.data[affbg_pkg::MODE_W-1:0];
				affbg_pkg::REG_SIZE:       cfg_q.size_sel <= wr.data[affbg_pkg::SIZE_W-1:0];
				affbg_pkg::REG_LAYER_BASE: cfg_q.layer_base <= wr.data[affbg_pkg::BASE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/affbg_walk.sv
// Reference point walker: accumulators, mosaic and pixel counters, stage 1 register.
// Depends on affbg_pkg.
`default_nettype none

module affbg_walk (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  advance,
	input  wire logic                                  start_line,
	input  wire logic signed [affbg_pkg::REF_W-1:0]    ref_x_in,
	input  wire logic signed [affbg_pkg::REF_W-1:0]    ref_y_in,
	input  affbg_pkg::cfg_t                            cfg,
	output affbg_pkg::coord_t                          coord_s1
);

	localparam int AW = affbg_pkg::ACC_W;
	localparam int MW = affbg_pkg::MW_W;
	localparam int PW = affbg_pkg::PIX_W;
	localparam int MUL_W = affbg_pkg::DX_W + MW + 1;

	logic [AW-1:0]           acc_x_q, acc_y_q, acc_x_cur, acc_y_cur, acc_x_nxt, acc_y_nxt;
	logic [MW-1:0]           mc_q, mc_cur, mc_inc, mc_nxt;
	logic [PW-1:0]           pc_q, pc_cur, pc_nxt;
	logic signed [MUL_W-1:0] mul_x, mul_y;
	logic                    last_pix;

	assign mul_x = $signed({1'b0, cfg.mosaic_width}) * cfg.dx;
	assign mul_y = $signed({1'b0, cfg.mosaic_width}) * cfg.dy;

	always_comb begin
		acc_x_cur = start_line ? AW'(ref_x_in) : acc_x_q;
		acc_y_cur = start_line ? AW'(ref_y_in) : acc_y_q;
		mc_cur    = start_line ? '0 : mc_q;
		pc_cur    = start_line ? '0 : pc_q;
		mc_inc    = mc_cur + MW'(1);
		last_pix  = (pc_cur == PW'(affbg_pkg::LINE_PIXELS - 1));
		pc_nxt    = last_pix ? '0 : pc_cur + PW'(1);
		if (cfg.mosaic_en) begin
			if (mc_inc == cfg.mosaic_width) begin
				acc_x_nxt = acc_x_cur + AW'(mul_x);
				acc_y_nxt = acc_y_cur + AW'(mul_y);
				mc_nxt    = '0;
			end else begin
				acc_x_nxt = acc_x_cur;
				acc_y_nxt = acc_y_cur;
				mc_nxt    = mc_inc;
			end
		end else begin
			acc_x_nxt = acc_x_cur + AW'(cfg.dx);
			acc_y_nxt = acc_y_cur + AW'(cfg.dy);
			mc_nxt    = mc_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			mc_q    <= '0;
			pc_q    <= '0;
		end else if (advance) begin
			acc_x_q <= acc_x_nxt;
			acc_y_q <= acc_y_nxt;
			mc_q    <= mc_nxt;
			pc_q    <= pc_nxt;
		end
	end

	// integer part: arithmetic shift right by 8
	always_ff @(posedge clk) begin
		if (advance) begin
			coord_s1.cx       <= $signed(acc_x_cur[AW-1:8]);
			coord_s1.cy       <= $signed(acc_y_cur[AW-1:8]);
			coord_s1.pixel_x  <= affbg_pkg::PIXX_W'(pc_cur);
			coord_s1.line_end <= last_pix;
		end
	end

endmodule

`default_nettype wire

### rtl/core/affbg_addr.sv
// Layer size, wrap or range check, fetch address; result register (stage 2).
// Depends on affbg_pkg.
`default_nettype none

module affbg_addr (
	input  wire logic          clk,
	input  wire logic          load,
	input  affbg_pkg::coord_t  coord_s1,
	input  affbg_pkg::cfg_t    cfg,
	output affbg_pkg::result_t res_s2
);

	localparam int TW = affbg_pkg::TEX_W;
	localparam int CW = affbg_pkg::COORD_W;
	localparam int SW = TW + TW + 1;

	logic [3:0]    wl, hl;
	logic          mode_ok, in_x, in_y, in_layer;
	logic [TW-1:0] mask_w, mask_h, tx, ty;
	logic [SW-1:0] tile_idx, lin, base, addr;
	affbg_pkg::result_t res;

	always_comb begin
		mode_ok = 1'b1;
		unique case (cfg.layer_mode)
			affbg_pkg::MODE_BYTE_MAP, affbg_pkg::MODE_HALF_MAP: begin
				wl = 4'd7 + 4'(cfg.size_sel);
				hl = wl;
			end
			affbg_pkg::MODE_BYTE_BMP, affbg_pkg::MODE_DIRECT_BMP: begin
				wl = cfg.size_sel[1] ? 4'd9 : (cfg.size_sel[0] ? 4'd8 : 4'd7);
				hl = (cfg.size_sel == 2'd3) ? 4'd9 : (cfg.size_sel == 2'd0 ? 4'd7 : 4'd8);
			end
			affbg_pkg::MODE_LARGE_BMP: begin
				wl = cfg.size_sel[0] ? 4'd10 : 4'd9;
				hl = cfg.size_sel[0] ? 4'd9 : 4'd10;
			end
			default: begin
				wl      = 4'd7;
				hl      = 4'd7;
				mode_ok = 1'b0;
			end
		endcase

		mask_w   = TW'((11'd1 << wl) - 11'd1);
		mask_h   = TW'((11'd1 << hl) - 11'd1);
		in_x     = cfg.wrap_en || (!coord_s1.cx[CW-1] && ((coord_s1.cx[CW-2:0] >> wl) == '0));
		in_y     = cfg.wrap_en || (!coord_s1.cy[CW-1] && ((coord_s1.cy[CW-2:0] >> hl) == '0));
		in_layer = mode_ok && in_x && in_y;
		tx       = coord_s1.cx[TW-1:0] & mask_w;
		ty       = coord_s1.cy[TW-1:0] & mask_h;

		tile_idx = (SW'(ty[TW-1:3]) << (3'd4 + 3'(cfg.size_sel))) + SW'(tx[TW-1:3]);
		lin      = (SW'(ty) << wl) + SW'(tx);
		base     = SW'(cfg.layer_base);

		unique case (cfg.layer_mode)
			affbg_pkg::MODE_BYTE_MAP:   addr = base + tile_idx;
			affbg_pkg::MODE_HALF_MAP:   addr = base + (tile_idx << 1);
			affbg_pkg::MODE_BYTE_BMP:   addr = base + lin;
			affbg_pkg::MODE_DIRECT_BMP: addr = base + (lin << 1);
			default:                    addr = lin;
		endcase

		res.pixel_x  = coord_s1.pixel_x;
		res.line_end = coord_s1.line_end;
		res.outside  = !in_layer;
		if (in_layer) begin
			res.tex_x         = tx;
			res.tex_y         = ty;
			res.fetch_address = addr[affbg_pkg::ADDR_W-1:0];
			res.fetch_wide    = (cfg.layer_mode == affbg_pkg::MODE_HALF_MAP) ||
				(cfg.layer_mode == affbg_pkg::MODE_DIRECT_BMP);
		end else begin
			res.tex_x         = '0;
			res.tex_y         = '0;
			res.fetch_address = '0;
			res.fetch_wide    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

### rtl/core/affine_background_address_gen_top.sv
// Top level of the affine background address generator.
// Depends on affbg_pkg, affbg_ifs, affbg_cfg, affbg_walk, affbg_addr and the macros header.
//
// Usage:
//  in_ch  : one transfer per pixel. start_line = 1 loads the 20.8 reference
//           point and restarts the pixel and mosaic counters; that item is pixel 0.
//  out_ch : one result per input transfer, in order: pixel_x, tex_x/tex_y,
//           outside, fetch_address and fetch_wide, line_end on the last pixel.
//  cfg    : register writes (index, data); always ready. Write only while idle.
// Pipeline: stage 1 register after the reference accumulators, then the stage 2
//  result register after the size/wrap/address logic.
// Throughput: one pixel per cycle while out_ch takes results; the loop that sets
//  it is the reference accumulator update (one 5x16 multiply and a 32 bit add).
// Reset: registers take their documented values, accumulators and counters
//  clear, both stages empty.
// Stall: a held result stays on out_ch; one more item is taken into stage 1,
//  after which in_ch.ready drops until the result is taken.
`default_nettype none

`include "affine_background_address_gen_top_macros.svh"

module affine_background_address_gen_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	affbg_in_if.sink    in_ch,
	affbg_out_if.source out_ch,
	affbg_cfg_if.sink   cfg
);

	affbg_pkg::cfg_t    cfg_r;
	affbg_pkg::coord_t  coord_s1;
	affbg_pkg::result_t res_s2;

	logic v_s1_q, v_out_q, in_acc, out_load;

	assign out_load    = v_s1_q && (!v_out_q || out_ch.ready);
	assign in_ch.ready = !v_s1_q || out_load;
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q  <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1_q <= 1'b1;
			end else if (out_load) begin
				v_s1_q <= 1'b0;
			end
			if (out_load) begin
				v_out_q <= 1'b1;
			end else if (out_ch.ready) begin
				v_out_q <= 1'b0;
			end
		end
	end

	affbg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.cfg_o  (cfg_r)
	);

	affbg_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (in_acc),
		.start_line (in_ch.start_line),
		.ref_x_in   (in_ch.ref_x_in),
		.ref_y_in   (in_ch.ref_y_in),
		.cfg        (cfg_r),
		.coord_s1   (coord_s1)
	);

	affbg_addr u_addr (
		.clk      (clk),
		.load     (out_load),
		.coord_s1 (coord_s1),
		.cfg      (cfg_r),
		.res_s2   (res_s2)
	);

	assign out_ch.valid         = v_out_q;
	assign out_ch.pixel_x       = res_s2.pixel_x;
	assign out_ch.tex_x         = res_s2.tex_x;
	assign out_ch.tex_y         = res_s2.tex_y;
	assign out_ch.outside       = res_s2.outside;
	assign out_ch.fetch_address = res_s2.fetch_address;
	assign out_ch.fetch_wide    = res_s2.fetch_wide;
	assign out_ch.line_end      = res_s2.line_end;

	`AFFBG_AST_NEXT(a_start_pix0, clk, arst_n, in_acc && in_ch.start_line, coord_s1.pixel_x == '0)
	`AFFBG_AST_IMPL(a_outside_clr, clk, arst_n, v_out_q && res_s2.outside, res_s2.fetch_address == '0 && !res_s2.fetch_wide && res_s2.tex_x == '0 && res_s2.tex_y == '0)
	`AFFBG_AST_NEXT(a_s1_hold, clk, arst_n, v_s1_q && !out_load, v_s1_q && v_out_q)

endmodule

`default_nettype wire

### sim/tb_affine_background_address_gen_top.sv
// Testbench for affine_background_address_gen_top: drives pixel items and register writes,
// predicts every pixel result and checks it field by field as it leaves the block.
// Depends on affbg_pkg, the channel interfaces in affbg_ifs and the top level.
`default_nettype none

module tb_affine_background_address_gen_top;
	timeunit 1ns;
	timeprecision 1ps;

	import affbg_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n;

	affbg_in_if  in_ch ();
	affbg_out_if out_ch ();
	affbg_cfg_if cfg ();

	affine_background_address_gen_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always #10 clk = ~clk;

	// predictor state and register copy
	cfg_t             layer_cfg;
	logic [ACC_W-1:0] acc_x, acc_y;
	logic [MW_W-1:0]  block_cnt;
	int               line_pos;

	result_t pending_pixels[$];
	int      failures = 0;
	int      in_idle_pct = 10;
	int      out_idle_pct = 10;
	int      hold_req = 0;
	int      stuck_cycles = 0;

	function automatic logic fit_coord(input logic [31:0] c, input logic [31:0] size,
		output logic [31:0] res);
		res = c;
		if (layer_cfg.wrap_en) begin
			res = c & (size - 1);
			return 1'b1;
		end
		return !(c[31] || c >= size);
	endfunction

	function automatic result_t next_pixel(input logic start, input logic [REF_W-1:0] rx,
		input logic [REF_W-1:0] ry);
		result_t     r;
		logic [31:0] cx, cy, w, h, tx, ty, map_cell, addr, step_x, step_y;
		logic        known, in_layer;
		int unsigned s;
		r = '0;
		if (start) begin
			acc_x = {{(ACC_W-REF_W){rx[REF_W-1]}}, rx};
			acc_y = {{(ACC_W-REF_W){ry[REF_W-1]}}, ry};
			block_cnt = '0;
			line_pos = 0;
		end
		cx = $signed(acc_x) >>> 8;
		cy = $signed(acc_y) >>> 8;
		step_x = {{16{layer_cfg.dx[15]}}, layer_cfg.dx};
		step_y = {{16{layer_cfg.dy[15]}}, layer_cfg.dy};
		if (layer_cfg.mosaic_en) begin
			block_cnt = block_cnt + 1'b1;
			if (block_cnt == layer_cfg.mosaic_width) begin
				acc_x = acc_x + step_x * layer_cfg.mosaic_width;
				acc_y = acc_y + step_y * layer_cfg.mosaic_width;
				block_cnt = '0;
			end
		end else begin
			acc_x = acc_x + step_x;
			acc_y = acc_y + step_y;
		end

		s = layer_cfg.size_sel;
		known = 1'b1;
		case (layer_cfg.layer_mode)
			MODE_BYTE_MAP, MODE_HALF_MAP: begin
				w = 32'd128 << s;
				h = w;
			end
			MODE_BYTE_BMP, MODE_DIRECT_BMP: begin
				w = (s >= 2) ? 32'd512 : (32'd128 << s);
				h = (s == 3) ? 32'd512 : ((s == 0) ? 32'd128 : 32'd256);
			end
			MODE_LARGE_BMP: begin
				w = 32'd512 << (s & 1);
				h = 32'd1024 >> (s & 1);
			end
			default: begin
				w = 32'd128;
				h = 32'd128;
				known = 1'b0;
			end
		endcase

		tx = 0;
		ty = 0;
		in_layer = known && fit_coord(cx, w, tx) && fit_coord(cy, h, ty);
		addr = 0;
		if (in_layer) begin
			map_cell = (ty >> 3) * (32'd16 << s) + (tx >> 3);
			case (layer_cfg.layer_mode)
				MODE_BYTE_MAP:   addr = layer_cfg.layer_base + map_cell;
				MODE_HALF_MAP:   addr = layer_cfg.layer_base + map_cell * 2;
				MODE_BYTE_BMP:   addr = layer_cfg.layer_base + ty * w + tx;
				MODE_DIRECT_BMP: addr = layer_cfg.layer_base + (ty * w + tx) * 2;
				default:         addr = ty * w + tx;
			endcase
			r.tex_x = tx[TEX_W-1:0];
			r.tex_y = ty[TEX_W-1:0];
			r.fetch_address = addr[ADDR_W-1:0];
			r.fetch_wide = (layer_cfg.layer_mode == MODE_HALF_MAP) ||
				(layer_cfg.layer_mode == MODE_DIRECT_BMP);
		end
		r.outside = !in_layer;
		r.pixel_x = line_pos[PIXX_W-1:0];
		r.line_end = (line_pos == LINE_PIXELS - 1);
		line_pos = (line_pos + 1 >= LINE_PIXELS) ? 0 : line_pos + 1;
		return r;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_DX:         layer_cfg.dx = d[DX_W-1:0];
			REG_DY:         layer_cfg.dy = d[DX_W-1:0];
			REG_MOSAIC_EN:  layer_cfg.mosaic_en = d[0];
			REG_MOSAIC_W:   layer_cfg.mosaic_width = d[MW_W-1:0];
			REG_WRAP_EN:    layer_cfg.wrap_en = d[0];
			REG_MODE:       layer_cfg.layer_mode = d[MODE_W-1:0];
			REG_SIZE:       layer_cfg.size_sel = d[SIZE_W-1:0];
			REG_LAYER_BASE: layer_cfg.layer_base = d[BASE_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			failures++;
		end
	endfunction

	// register writes, pixel transfers in and results out, all sampled at the edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				apply_reg(cfg.index, cfg.data);
			if (in_ch.valid && in_ch.ready)
				pending_pixels.push_back(next_pixel(in_ch.start_line, in_ch.ref_x_in,
					in_ch.ref_y_in));
			if (out_ch.valid && out_ch.ready) begin
				if (pending_pixels.size() == 0) begin
					$error("result transfer with no pixel outstanding");
					failures++;
				end else begin
					want = pending_pixels.pop_front();
					check_field("pixel_x", 32'(want.pixel_x), 32'(out_ch.pixel_x));
					check_field("tex_x", 32'(want.tex_x), 32'(out_ch.tex_x));
					check_field("tex_y", 32'(want.tex_y), 32'(out_ch.tex_y));
					check_field("outside", 32'(want.outside), 32'(out_ch.outside));
					check_field("fetch_address", 32'(want.fetch_address),
						32'(out_ch.fetch_address));
					check_field("fetch_wide", 32'(want.fetch_wide), 32'(out_ch.fetch_wide));
					check_field("line_end", 32'(want.line_end), 32'(out_ch.line_end));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg.valid && cfg.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("affine_background_address_gen_top verification failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
			end
		end
	end

	task automatic send_pixel(input logic start, input logic [REF_W-1:0] rx,
		input logic [REF_W-1:0] ry);
		while ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.start_line <= start;
		in_ch.ref_x_in <= rx;
		in_ch.ref_y_in <= ry;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic load_settings(input cfg_t s);
		drain();
		write_reg(REG_DX, CFG_DATA_W'(s.dx));
		write_reg(REG_DY, CFG_DATA_W'(s.dy));
		write_reg(REG_MOSAIC_EN, CFG_DATA_W'(s.mosaic_en));
		write_reg(REG_MOSAIC_W, CFG_DATA_W'(s.mosaic_width));
		write_reg(REG_WRAP_EN, CFG_DATA_W'(s.wrap_en));
		write_reg(REG_MODE, CFG_DATA_W'(s.layer_mode));
		write_reg(REG_SIZE, CFG_DATA_W'(s.size_sel));
		write_reg(REG_LAYER_BASE, CFG_DATA_W'(s.layer_base));
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [DX_W-1:0] pick_step();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return DX_W'($urandom());
			default: return DX_W'(int'($urandom_range(1024)) - 512);
		endcase
	endfunction

	function automatic cfg_t random_settings();
		cfg_t s;
		s.dx = pick_step();
		s.dy = pick_step();
		s.mosaic_en = ($urandom_range(2) == 0);
		s.mosaic_width = ($urandom_range(7) == 0) ? MW_W'($urandom_range(31)) :
			MW_W'($urandom_range(1, 16));
		s.wrap_en = 1'($urandom_range(1));
		s.layer_mode = ($urandom_range(9) == 0) ? MODE_W'($urandom_range(5, 7)) :
			MODE_W'($urandom_range(4));
		s.size_sel = SIZE_W'($urandom_range(3));
		case ($urandom_range(3))
			0: s.layer_base = '0;
			1: s.layer_base = '1;
			default: s.layer_base = BASE_W'($urandom());
		endcase
		return s;
	endfunction

	// mostly near the layer so that walks stay inside, sometimes anywhere
	function automatic logic [REF_W-1:0] random_ref();
		int c;
		if ($urandom_range(4) == 0)
			return REF_W'($urandom());
		c = int'($urandom_range(1087)) - 32;
		return REF_W'(c * 256) | REF_W'($urandom_range(255));
	endfunction

	task automatic run_lines(input int n_items, input int max_run);
		int sent, run;
		sent = 0;
		while (sent < n_items) begin
			send_pixel(1'b1, random_ref(), random_ref());
			sent++;
			run = $urandom_range(max_run);
			repeat (run) begin
				send_pixel($urandom_range(49) == 0, random_ref(), random_ref());
				sent++;
			end
		end
	endtask

	task automatic test_defaults();
		send_pixel(1'b1, '0, '0);
		repeat (3) send_pixel(1'b0, random_ref(), random_ref());
	endtask

	task automatic test_coord_extremes();
		load_settings('{dx: 16'sh8000, dy: 16'sh7FFF, mosaic_en: 1'b0, mosaic_width: 5'd1,
			wrap_en: 1'b1, layer_mode: MODE_LARGE_BMP, size_sel: 2'd1, layer_base: '1});
		send_pixel(1'b1, 28'h7FFFFFF, 28'h8000000);
		send_pixel(1'b0, 28'h8000000, 28'h7FFFFFF);
		send_pixel(1'b1, 28'h8000000, 28'h7FFFFFF);
		send_pixel(1'b0, 28'h7FFFFFF, 28'h8000000);
	endtask

	task automatic test_wrap_and_outside();
		load_settings('{dx: 16'sd256, dy: 16'sd256, mosaic_en: 1'b0, mosaic_width: 5'd1,
			wrap_en: 1'b1, layer_mode: MODE_BYTE_BMP, size_sel: 2'd0, layer_base: 19'h100});
		// one pixel left of and above the origin wraps to the far edge
		send_pixel(1'b1, 28'hFFFFF00, 28'hFFFFF00);
		send_pixel(1'b0, '0, '0);
		load_settings('{dx: 16'sd256, dy: 16'sd256, mosaic_en: 1'b0, mosaic_width: 5'd1,
			wrap_en: 1'b0, layer_mode: MODE_BYTE_BMP, size_sel: 2'd0, layer_base: 19'h100});
		send_pixel(1'b1, 28'hFFFFF00, 28'hFFFFF00);
		send_pixel(1'b1, 28'(127 * 256), 28'(128 * 256));
	endtask

	task automatic test_layer_modes();
		logic [MODE_W-1:0] modes[4];
		modes = '{MODE_HALF_MAP, MODE_DIRECT_BMP, 3'd5, 3'd7};
		foreach (modes[i]) begin
			load_settings('{dx: 16'sd384, dy: -16'sd100, mosaic_en: 1'b0, mosaic_width: 5'd1,
				wrap_en: 1'b0, layer_mode: modes[i], size_sel: 2'd3, layer_base: '1});
			send_pixel(1'b1, 28'(300 * 256 + 128), 28'(200 * 256 + 64));
		end
	endtask

	task automatic test_mosaic_zero_width();
		load_settings('{dx: 16'sd700, dy: 16'sd300, mosaic_en: 1'b1, mosaic_width: 5'd0,
			wrap_en: 1'b1, layer_mode: MODE_BYTE_MAP, size_sel: 2'd3, layer_base: 19'h4000});
		send_pixel(1'b1, 28'(50 * 256), 28'(60 * 256));
		repeat (5) send_pixel(1'b0, random_ref(), random_ref());
	endtask

	task automatic test_random_settings();
		repeat (8) begin
			load_settings(random_settings());
			run_lines(60, 40);
		end
	endtask

	// a line longer than the screen, with neither side idling
	task automatic test_line_overrun();
		cfg_t s;
		s = random_settings();
		s.layer_mode = MODE_BYTE_BMP;
		s.wrap_en = 1'b1;
		load_settings(s);
		in_idle_pct = 0;
		out_idle_pct = 0;
		send_pixel(1'b1, random_ref(), random_ref());
		repeat (299) send_pixel(1'b0, random_ref(), random_ref());
		in_idle_pct = 10;
		out_idle_pct = 10;
	endtask

	task automatic test_output_hold_off();
		load_settings(random_settings());
		hold_req = HOLD_CYCLES;
		run_lines(40, 40);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.start_line <= 1'b0;
		in_ch.ref_x_in <= '0;
		in_ch.ref_y_in <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		layer_cfg = '0;
		layer_cfg.dx = 16'sd256;
		layer_cfg.mosaic_width = 5'd1;
		acc_x = '0;
		acc_y = '0;
		block_cnt = '0;
		line_pos = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_coord_extremes();
		test_wrap_and_outside();
		test_layer_modes();
		test_mosaic_zero_width();
		test_random_settings();
		test_line_overrun();
		test_output_hold_off();

		drain();
		repeat (8) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			$error("%0d pixel results never arrived", pending_pixels.size());
			failures++;
		end
		if (failures == 0)
			$display("affine_background_address_gen_top verification clean");
		else
			$display("affine_background_address_gen_top verification failed");
		$finish;
	end

endmodule

`default_nettype wire
